/* hdl/camera_image_package_download_top_assert.svh */
// Assertion macros shared by the picture download block
`ifndef CAMERA_IMAGE_PACKAGE_DOWNLOAD_TOP_ASSERT_SVH
`define CAMERA_IMAGE_PACKAGE_DOWNLOAD_TOP_ASSERT_SVH

// ante implies cons in the same cycle
`define CIPD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// ante implies cons in the next cycle
`define CIPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/cipd_pkg.sv */
// Types, codes and byte tables of the picture download block
package cipd_pkg;

  localparam logic [1:0] CMD_START   = 2'd0;
  localparam logic [1:0] CMD_BYTE    = 2'd1;
  localparam logic [1:0] CMD_REQUEST = 2'd2;

  localparam logic [1:0] KIND_SEND    = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_STATUS  = 2'd2;

  localparam logic [2:0] ST_NONE     = 3'd0;
  localparam logic [2:0] ST_READY    = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_PKG_DONE = 3'd3;
  localparam logic [2:0] ST_COMPLETE = 3'd4;
  localparam logic [2:0] ST_IGNORED  = 3'd5;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_ACK   = 3'd1;
  localparam logic [2:0] PH_SIZE  = 3'd2;
  localparam logic [2:0] PH_READY = 3'd3;
  localparam logic [2:0] PH_RECV  = 3'd4;

  localparam logic [2:0] SEQ_NONE    = 3'd0;
  localparam logic [2:0] SEQ_GETPIC  = 3'd1;
  localparam logic [2:0] SEQ_REQ     = 3'd2;
  localparam logic [2:0] SEQ_FINISH  = 3'd3;
  localparam logic [2:0] SEQ_STATUS  = 3'd4;
  localparam logic [2:0] SEQ_PAYLOAD = 3'd5;

  localparam logic [7:0] PAYLOAD_RESET = 8'd58;
  localparam logic [7:0] PAYLOAD_MAX   = 8'd249;
  localparam logic [7:0] FRAME_BYTES   = 8'd6;
  localparam logic [3:0] FINISH_LAST   = 4'd12;
  localparam logic [3:0] SEND_LAST     = 4'd5;

  typedef struct packed {
    logic [2:0]  seq;
    logic [7:0]  data;
    logic [2:0]  status;
    logic [23:0] size;
    logic [7:0]  pay;
    logic [15:0] pkg;
  } desc_t;

  function automatic logic [7:0] ack_pat_byte(input logic [2:0] i);
    case (i)
      3'd0:    return 8'hAA;
      3'd1:    return 8'h0E;
      3'd2:    return 8'h04;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [3:0] last_idx(input logic [2:0] seq);
    case (seq)
      SEQ_GETPIC, SEQ_REQ: return SEND_LAST;
      SEQ_FINISH:          return FINISH_LAST;
      default:             return 4'd0;
    endcase
  endfunction

  function automatic logic [7:0] send_byte(input logic [2:0] seq, input logic [3:0] idx,
                                           input logic [15:0] pkg);
    logic [7:0] b;
    b = 8'h00;
    case (seq)
      SEQ_GETPIC: begin
        case (idx)
          4'd0:    b = 8'hAA;
          4'd1:    b = 8'h04;
          4'd2:    b = 8'h01;
          default: b = 8'h00;
        endcase
      end
      SEQ_REQ: begin
        case (idx)
          4'd0:    b = 8'hAA;
          4'd1:    b = 8'h0E;
          4'd4:    b = pkg[7:0];
          4'd5:    b = pkg[15:8];
          default: b = 8'h00;
        endcase
      end
      SEQ_FINISH: begin
        case (idx)
          4'd0, 4'd6: b = 8'hAA;
          4'd1:       b = 8'h0E;
          4'd4, 4'd5: b = 8'hF0;
          4'd7:       b = 8'h08;
          default:    b = 8'h00;
        endcase
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* hdl/cipd_if.sv */
// Input and result channel interfaces of the picture download block
interface cipd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] rx_byte;

  modport source (output valid, command, rx_byte, input ready);
  modport sink (input valid, command, rx_byte, output ready);
endinterface

interface cipd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data;
  logic [2:0]  status;
  logic [23:0] image_size;
  logic [7:0]  package_payload;
  logic        last;

  modport source (output valid, kind, data, status, image_size, package_payload, last,
                  input ready);
  modport sink (input valid, kind, data, status, image_size, package_payload, last,
                output ready);
endinterface

/* hdl/cipd_ctrl.sv */
// Download sequencer: protocol state and at most one result descriptor per input word
module cipd_ctrl
  import cipd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [1:0]  command,
  input  logic [7:0]  rx_byte,
  input  logic [7:0]  payload_bytes,
  output desc_t       desc
);

  logic [2:0]  phase, phase_next;
  logic [2:0]  match_count, match_count_next;
  logic [2:0]  size_byte_index, size_byte_index_next;
  logic [23:0] size_collect, size_collect_next;
  logic [23:0] remaining_bytes, remaining_bytes_next;
  logic [15:0] package_number, package_number_next;
  logic [7:0]  byte_in_package, byte_in_package_next;
  logic [7:0]  package_length, package_length_next;

  logic [7:0]  pb_eff;
  logic [7:0]  chunk;
  logic [7:0]  pat;
  logic [23:0] sc_new;
  logic [8:0]  bip_ext;
  logic [8:0]  len_ext;

  always_comb begin
    if (payload_bytes == 8'd0) begin
      pb_eff = 8'd1;
    end else if (payload_bytes > PAYLOAD_MAX) begin
      pb_eff = PAYLOAD_MAX;
    end else begin
      pb_eff = payload_bytes;
    end
    chunk = (remaining_bytes < {16'd0, pb_eff}) ? remaining_bytes[7:0] : pb_eff;
    pat = ack_pat_byte((match_count > 3'd5) ? 3'd5 : match_count);
    bip_ext = {1'b0, byte_in_package};
    len_ext = {1'b0, package_length};
    sc_new = size_collect;
    case (size_byte_index)
      3'd3:    sc_new[7:0]   = size_collect[7:0] | rx_byte;
      3'd4:    sc_new[15:8]  = size_collect[15:8] | rx_byte;
      3'd5:    sc_new[23:16] = size_collect[23:16] | rx_byte;
      default: sc_new = size_collect;
    endcase

    phase_next = phase;
    match_count_next = match_count;
    size_byte_index_next = size_byte_index;
    size_collect_next = size_collect;
    remaining_bytes_next = remaining_bytes;
    package_number_next = package_number;
    byte_in_package_next = byte_in_package;
    package_length_next = package_length;
    desc = '0;
    desc.seq = SEQ_NONE;

    case (command)
      CMD_START: begin
        desc.seq = SEQ_GETPIC;
        phase_next = PH_ACK;
        match_count_next = 3'd0;
        size_byte_index_next = 3'd0;
        size_collect_next = 24'd0;
        byte_in_package_next = 8'd0;
      end
      CMD_BYTE: begin
        case (phase)
          PH_ACK: begin
            if (rx_byte == pat || pat == 8'h00) begin
              match_count_next = match_count + 3'd1;
              if (match_count >= 3'd5) begin
                phase_next = PH_SIZE;
                size_byte_index_next = 3'd0;
                size_collect_next = 24'd0;
              end
            end
          end
          PH_SIZE: begin
            size_collect_next = sc_new;
            size_byte_index_next = size_byte_index + 3'd1;
            if (size_byte_index >= 3'd5) begin
              size_byte_index_next = 3'd0;
              desc.seq = SEQ_STATUS;
              if (sc_new == 24'd0) begin
                phase_next = PH_IDLE;
                desc.status = ST_EMPTY;
              end else begin
                remaining_bytes_next = sc_new;
                phase_next = PH_READY;
                desc.status = ST_READY;
                desc.size = sc_new;
              end
            end
          end
          PH_RECV: begin
            if (byte_in_package >= 8'd4 && bip_ext + 9'd2 < len_ext) begin
              desc.seq = SEQ_PAYLOAD;
              desc.data = rx_byte;
              if (remaining_bytes != 24'd0) begin
                remaining_bytes_next = remaining_bytes - 24'd1;
              end
            end
            byte_in_package_next = byte_in_package + 8'd1;
            if (bip_ext + 9'd1 >= len_ext) begin
              desc.pay = package_length - FRAME_BYTES;
              package_number_next = package_number + 16'd1;
              byte_in_package_next = 8'd0;
              if (remaining_bytes_next == 24'd0) begin
                desc.seq = SEQ_FINISH;
                desc.status = ST_COMPLETE;
                phase_next = PH_IDLE;
                package_number_next = 16'd0;
                match_count_next = 3'd0;
                size_byte_index_next = 3'd0;
                package_length_next = 8'd0;
              end else begin
                desc.seq = SEQ_STATUS;
                desc.status = ST_PKG_DONE;
                phase_next = PH_READY;
              end
            end
          end
          default: begin
            desc.seq = SEQ_STATUS;
            desc.status = ST_IGNORED;
          end
        endcase
      end
      CMD_REQUEST: begin
        if (phase == PH_READY) begin
          desc.seq = SEQ_REQ;
          desc.pkg = package_number;
          package_length_next = chunk + FRAME_BYTES;
          byte_in_package_next = 8'd0;
          phase_next = PH_RECV;
        end else begin
          desc.seq = SEQ_STATUS;
          desc.status = ST_IGNORED;
        end
      end
      default: begin
        desc.seq = SEQ_STATUS;
        desc.status = ST_IGNORED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      match_count <= 3'd0;
      size_byte_index <= 3'd0;
      size_collect <= 24'd0;
      remaining_bytes <= 24'd0;
      package_number <= 16'd0;
      byte_in_package <= 8'd0;
      package_length <= 8'd0;
    end else if (accept) begin
      phase <= phase_next;
      match_count <= match_count_next;
      size_byte_index <= size_byte_index_next;
      size_collect <= size_collect_next;
      remaining_bytes <= remaining_bytes_next;
      package_number <= package_number_next;
      byte_in_package <= byte_in_package_next;
      package_length <= package_length_next;
    end
  end

endmodule

/* hdl/cipd_emit.sv */
// Result expander: turns a held descriptor into result words, one per cycle while dout is not stalled
module cipd_emit
  import cipd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              desc_valid,
  input  desc_t             desc,
  output logic              desc_ready,
  cipd_out_if.source        dout
);

`include "camera_image_package_download_top_assert.svh"

  logic        busy;
  logic [3:0]  idx;
  desc_t       cur;
  logic        adv;
  logic        at_last;
  logic        load;

  logic [1:0]  kind_next;
  logic [7:0]  data_next;
  logic [2:0]  status_next;
  logic [23:0] size_next;
  logic [7:0]  pay_next;

  assign adv = busy && (!dout.valid || dout.ready);
  assign at_last = (idx == last_idx(cur.seq));
  assign desc_ready = !busy || (adv && at_last);
  assign load = desc_valid && desc_ready;

  always_comb begin
    kind_next = KIND_STATUS;
    data_next = 8'd0;
    status_next = ST_NONE;
    size_next = 24'd0;
    pay_next = 8'd0;
    case (cur.seq)
      SEQ_GETPIC, SEQ_REQ: begin
        kind_next = KIND_SEND;
        data_next = send_byte(cur.seq, idx, cur.pkg);
      end
      SEQ_FINISH: begin
        if (idx == FINISH_LAST) begin
          status_next = cur.status;
          pay_next = cur.pay;
        end else begin
          kind_next = KIND_SEND;
          data_next = send_byte(cur.seq, idx, cur.pkg);
        end
      end
      SEQ_PAYLOAD: begin
        kind_next = KIND_PAYLOAD;
        data_next = cur.data;
      end
      SEQ_STATUS: begin
        status_next = cur.status;
        size_next = cur.size;
        pay_next = cur.pay;
      end
      default: begin
        kind_next = KIND_STATUS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx <= 4'd0;
      dout.valid <= 1'b0;
    end else begin
      if (load) begin
        busy <= 1'b1;
        idx <= 4'd0;
      end else if (adv && at_last) begin
        busy <= 1'b0;
      end else if (adv) begin
        idx <= idx + 4'd1;
      end
      if (adv) begin
        dout.valid <= 1'b1;
      end else if (dout.ready) begin
        dout.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= desc;
    end
    if (adv) begin
      dout.kind <= kind_next;
      dout.data <= data_next;
      dout.status <= status_next;
      dout.image_size <= size_next;
      dout.package_payload <= pay_next;
      dout.last <= at_last;
    end
  end

  `CIPD_ASSERT_IMPL(a_idx_range, clk, rst, busy, idx <= last_idx(cur.seq), "index overran")
  `CIPD_ASSERT_NEXT(a_drain, clk, rst, adv && at_last && !load, !busy, "expander stuck")
  `CIPD_ASSERT_NEXT(a_last_word, clk, rst, adv && at_last, dout.valid && dout.last, "last lost")
  `CIPD_ASSERT_IMPL(a_status_data, clk, rst, dout.valid && dout.kind == KIND_STATUS,
                    dout.data == 8'd0, "status word with data")

endmodule

/* hdl/camera_image_package_download_top.sv */
// Camera picture download controller: top level with register port
// The descriptor of a taken word is registered, then each result word is registered on dout.
// Throughput: one input word a cycle while the expander has room; an input word
// with n results (1 to 13) holds the single-word result expander until all n are out.
// Input words with no result leave the expander alone but wait while it is busy.
// Reset: synchronous; clears protocol state, counters and valid flags, payload_bytes to 58.
module camera_image_package_download_top
  import cipd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  cipd_in_if.sink     din,
  cipd_out_if.source  dout
);

  logic [7:0] payload_bytes;
  logic       accept;
  logic       desc_ready;
  desc_t      desc;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {24'd0, payload_bytes} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_bytes <= PAYLOAD_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      payload_bytes <= pwdata[7:0];
    end
  end

  assign din.ready = desc_ready;
  assign accept = din.valid && din.ready;

  cipd_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .command       (din.command),
    .rx_byte       (din.rx_byte),
    .payload_bytes (payload_bytes),
    .desc          (desc)
  );

  cipd_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .desc_valid (accept && desc.seq != SEQ_NONE),
    .desc       (desc),
    .desc_ready (desc_ready),
    .dout       (dout)
  );

endmodule
